FILE: design/stg_pkg.sv
// Package for the sine tone generator: operation codes, default sizes,
// register reset values and the quarter-wave sine evaluation used to build the table.
// Has no dependencies of its own.
package stg_pkg;

  // Default sizes handed to the top level.
  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int COUNT_BITS_DEF      = 24;

  // Configuration registers.
  localparam int STEP_BITS = 31;
  localparam int GAIN_BITS = 16;
  localparam int DUR_FIELD_BITS = 24;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 31'd39370534;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4915;
  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 16'd32768;

  typedef enum logic {
    REG_PHASE_STEP = 1'b0,
    REG_GAIN       = 1'b1
  } stg_reg_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_PLAY  = 2'd2,
    OP_STOP  = 2'd3
  } stg_op_t;

  // Polynomial coefficients of sin(pi/2 * x) in Q30.
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598614;
  localparam logic [63:0] C5 = 64'd85569300;
  localparam logic [63:0] C7 = 64'd5027000;
  localparam logic [63:0] C9 = 64'd172270;

  // Magnitude of the table entry at position pos of the first quarter turn,
  // where the quarter holds 2^qbits positions and samples carry sbits bits.
  // Only evaluated at elaboration to fill the constant table.
  function automatic logic [63:0] quarter_mag(input int unsigned pos,
                                              input int unsigned qbits,
                                              input int unsigned sbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] amp;
    x   = 64'(pos) << (30 - qbits);
    x2  = (x * x) >> 30;
    p   = C9;
    p   = C7 - ((x2 * p) >> 30);
    p   = C5 - ((x2 * p) >> 30);
    p   = C3 - ((x2 * p) >> 30);
    p   = C1 - ((x2 * p) >> 30);
    s   = (x * p) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    amp = (64'd1 << (sbits - 1)) - 64'd1;
    return (s * amp + (64'd1 << 29)) >> 30;
  endfunction

endpackage

FILE: design/sine_tone_generator_core.sv
// Top level of the sine tone generator: phase accumulator, quarter-wave sine
// table, gain multiplier and a two-deep output register. Depends on stg_pkg.
//
// The generator takes one input word per clock cycle while the skid register is
// empty and gives one registered sample word per tick word; start, play and stop
// words give no output. The cycle is set by a single path from the phase register
// through the sine table lookup and one sample-by-gain multiplication into the
// output register. The output side has an output register and a skid register,
// so the input keeps accepting words until two samples wait unread. The sine
// table is a constant quarter-wave table of 2^(TABLE_ADDR_BITS-2) entries that
// is mirrored and negated for the other quadrants. The last sample of a tone
// carries out_tlast. The registers phase_step (index 0) and gain (index 1)
// should only be written while no samples are outstanding.
module sine_tone_generator_core #(
  parameter int PHASE_BITS      = stg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = stg_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS      = stg_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [stg_pkg::STEP_BITS-1:0]       cfg_wdata,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata fields from bit 0: duration_frames.
  input  logic [((stg_pkg::DUR_FIELD_BITS+7)/8)*8-1:0] in_tdata,
  // tuser fields from bit 0: op.
  input  logic [1:0]                          in_tuser,
  // Output stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata fields from bit 0: sample, zero padding.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,
  output logic                                out_tlast
);
  import stg_pkg::*;

  localparam int QB       = TABLE_ADDR_BITS - 2;
  localparam int QDEPTH   = 1 << QB;
  localparam int MAG_BITS = SAMPLE_BITS - 1;
  localparam int PW       = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int OUT_W    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int DUR_BITS = (COUNT_BITS < DUR_FIELD_BITS) ? COUNT_BITS : DUR_FIELD_BITS;
  localparam logic [MAG_BITS-1:0] AMP = '1;
  localparam logic signed [PW-1:0] SAT_HI = PW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

  // Configuration and generator state.
  logic [STEP_BITS-1:0]   phase_step_r;
  logic [GAIN_BITS-1:0]   gain_r;
  logic [PHASE_BITS-1:0]  phase_acc_r, phase_acc_nxt;
  logic [COUNT_BITS-1:0]  frames_r, frames_nxt;
  logic                   run_r, run_nxt;

  // Output register and skid register.
  logic                   out_valid_r, skid_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r, skid_sample_r;
  logic                   out_last_r, skid_last_r;

  logic                   in_acc;
  logic                   produce;
  logic                   live;
  stg_op_t                op;
  logic [COUNT_BITS-1:0]  dur;
  logic [COUNT_BITS-1:0]  frames_dec;
  logic [SAMPLE_BITS-1:0] new_sample;
  logic                   new_last;

  // Quarter-wave sine table, filled at elaboration.
  logic [MAG_BITS-1:0]    qtab [QDEPTH];

  for (genvar i = 0; i < QDEPTH; i++) begin : g_qtab
    assign qtab[i] = MAG_BITS'(quarter_mag(i, QB, SAMPLE_BITS));
  end

  // Table lookup and gain scaling for the current phase.
  logic [TABLE_ADDR_BITS-1:0]    addr;
  logic [1:0]                    quad;
  logic [QB-1:0]                 pos, qidx;
  logic [MAG_BITS-1:0]           mag;
  logic signed [SAMPLE_BITS-1:0] entry;
  logic [GAIN_BITS-1:0]          gain_c;
  logic signed [PW-1:0]          prod, scaled;

  always_comb begin
    addr   = phase_acc_r[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    quad   = addr[TABLE_ADDR_BITS-1 -: 2];
    pos    = addr[QB-1:0];
    qidx   = quad[0] ? (QB'(0) - pos) : pos;
    // The odd quadrants start at the crest, one past the end of the table.
    mag    = (quad[0] && (pos == '0)) ? AMP : qtab[qidx];
    entry  = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    gain_c = (gain_r > GAIN_UNITY) ? GAIN_UNITY : gain_r;
    prod   = PW'(entry) * $signed({1'b0, gain_c});
    scaled = (prod + PW'(1 << 14)) >>> 15;
    if (scaled > SAT_HI) begin
      scaled = SAT_HI;
    end else if (scaled < SAT_LO) begin
      scaled = SAT_LO;
    end
  end

  // Handshake and operation decode.
  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = stg_op_t'(in_tuser);
  assign produce   = in_acc && (op == OP_TICK);
  assign live      = run_r && (frames_r != '0);
  assign dur       = COUNT_BITS'(in_tdata[DUR_BITS-1:0]);
  assign frames_dec = frames_r - COUNT_BITS'(1);

  // Next generator state and the sample for a tick word.
  always_comb begin
    phase_acc_nxt = phase_acc_r;
    frames_nxt    = frames_r;
    run_nxt       = run_r;
    new_sample    = '0;
    new_last      = 1'b0;
    if (in_acc) begin
      unique case (op)
        OP_TICK: begin
          if (live) begin
            new_sample    = scaled[SAMPLE_BITS-1:0];
            phase_acc_nxt = phase_acc_r + PHASE_BITS'(phase_step_r);
            frames_nxt    = frames_dec;
            if (frames_dec == '0) begin
              run_nxt  = 1'b0;
              new_last = 1'b1;
            end
          end
        end
        OP_START: begin
          run_nxt = 1'b1;
        end
        OP_PLAY: begin
          frames_nxt = (dur == '0) ? COUNT_BITS'(1) : dur;
          run_nxt    = 1'b1;
        end
        OP_STOP: begin
          frames_nxt = '0;
          run_nxt    = 1'b0;
        end
        default: begin
          run_nxt = run_r;
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= STEP_RESET;
      gain_r       <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (stg_reg_t'(cfg_index))
        REG_PHASE_STEP: phase_step_r <= cfg_wdata;
        REG_GAIN:       gain_r       <= cfg_wdata[GAIN_BITS-1:0];
        default:        gain_r       <= gain_r;
      endcase
    end
  end

  // Generator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      frames_r    <= '0;
      run_r       <= 1'b0;
    end else begin
      phase_acc_r <= phase_acc_nxt;
      frames_r    <= frames_nxt;
      run_r       <= run_nxt;
    end
  end

  // Output register, backed by a skid register while the consumer stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= produce;
      end
    end else if (produce) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_sample_r <= skid_sample_r;
        out_last_r   <= skid_last_r;
      end else if (produce) begin
        out_sample_r <= new_sample;
        out_last_r   <= new_last;
      end
    end else if (produce) begin
      skid_sample_r <= new_sample;
      skid_last_r   <= new_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_sample_r);
  assign out_tlast  = out_last_r;

  // The skid register only fills behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the output register is empty");

  // The skid register is only occupied after the consumer stalled.
  a_skid_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid register filled without a stall");

  // The final sample of a tone stops the generator.
  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && live && (frames_r == COUNT_BITS'(1))) |=> (!run_r && (frames_r == '0)))
    else $error("tone did not stop after its last sample");

  // The phase only moves on a tick that plays a sample.
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(produce && live) |=> $stable(phase_acc_r))
    else $error("phase moved without a played sample");

endmodule

FILE: tb/sine_tone_checker.sv
// Checker for the sine tone generator: watches the configuration port and both
// streams, predicts every sample word and compares it with what the block gives.
// Depends on stg_pkg for the operation and register codes.
module sine_tone_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [stg_pkg::STEP_BITS-1:0] cfg_wdata,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  // tdata fields from bit 0: duration_frames.
  input  logic [23:0]                   in_tdata,
  // tuser fields from bit 0: op.
  input  logic [1:0]                    in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata fields from bit 0: sample.
  input  logic [15:0]                   out_tdata,
  input  logic                          out_tlast,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import stg_pkg::*;

  // Quarter-wave polynomial for sin(pi/2 * x), all in Q30.
  localparam logic [63:0] UNIT_Q30 = 64'd1073741824;
  localparam logic [63:0] SIN_K1   = 64'd1686629713;
  localparam logic [63:0] SIN_K3   = 64'd693598614;
  localparam logic [63:0] SIN_K5   = 64'd85569300;
  localparam logic [63:0] SIN_K7   = 64'd5027000;
  localparam logic [63:0] SIN_K9   = 64'd172270;
  localparam logic [63:0] PEAK     = 64'd32767;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } tone_word_t;

  // Predicted state of the generator.
  logic [31:0]          phase;
  logic [23:0]          tone_frames;
  logic                 running;
  logic [STEP_BITS-1:0] step_reg;
  logic [GAIN_BITS-1:0] gain_reg;

  tone_word_t expected_samples[$];

  // Signed table value for a 10-bit table address.
  function automatic int table_value(input logic [9:0] addr);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] mag;
    x = {56'd0, addr[7:0]} << 22;
    if (addr[8]) begin
      x = UNIT_Q30 - x;
    end
    x2 = (x * x) >> 30;
    p  = SIN_K7 - ((x2 * SIN_K9) >> 30);
    p  = SIN_K5 - ((x2 * p) >> 30);
    p  = SIN_K3 - ((x2 * p) >> 30);
    p  = SIN_K1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    if (s > UNIT_Q30) begin
      s = UNIT_Q30;
    end
    mag = (s * PEAK + (64'd1 << 29)) >> 30;
    return addr[9] ? -int'(mag) : int'(mag);
  endfunction

  // Applies one input word to the predicted state; returns 1 when a sample is due.
  function automatic logic tone_advance(input stg_op_t op, input logic [23:0] dur,
                                        output tone_word_t word);
    longint prod;
    longint scaled;
    longint g;
    word = '0;
    case (op)
      OP_START: begin
        running = 1'b1;
        return 1'b0;
      end
      OP_PLAY: begin
        tone_frames = (dur == 24'd0) ? 24'd1 : dur;
        running     = 1'b1;
        return 1'b0;
      end
      OP_STOP: begin
        running     = 1'b0;
        tone_frames = 24'd0;
        return 1'b0;
      end
      default: begin
        // A tick while stopped or with no frames left stays silent.
        if (running && tone_frames != 24'd0) begin
          g      = (gain_reg > GAIN_UNITY) ? longint'(GAIN_UNITY) : longint'(gain_reg);
          prod   = longint'(table_value(phase[31:22])) * g;
          scaled = (prod + 64'sd16384) >>> 15;
          if (scaled > 32767) begin
            scaled = 32767;
          end
          if (scaled < -32768) begin
            scaled = -32768;
          end
          word.sample = scaled[15:0];
          phase       = phase + {1'b0, step_reg};
          tone_frames = tone_frames - 24'd1;
          if (tone_frames == 24'd0) begin
            running   = 1'b0;
            word.last = 1'b1;
          end
        end
        return 1'b1;
      end
    endcase
  endfunction

  // Sample words first, then the newly accepted input word, then register writes.
  always @(posedge clk) begin
    tone_word_t want;
    tone_word_t next_word;
    if (!rst_n) begin
      phase       = '0;
      tone_frames = '0;
      running     = 1'b0;
      step_reg    = 31'd39370534;
      gain_reg    = 16'd4915;
      expected_samples.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $error("sample word with none expected: sample %0d, last %0b",
                 $signed(out_tdata), out_tlast);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if ($signed(out_tdata) !== want.sample) begin
            $error("sample mismatch: expected %0d, actual %0d",
                   want.sample, $signed(out_tdata));
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (tone_advance(stg_op_t'(in_tuser), in_tdata, next_word)) begin
          expected_samples.push_back(next_word);
        end
      end
      if (cfg_we) begin
        case (stg_reg_t'(cfg_index))
          REG_PHASE_STEP: step_reg = cfg_wdata;
          REG_GAIN:       gain_reg = cfg_wdata[GAIN_BITS-1:0];
          default:        ;
        endcase
      end
    end
    pending = expected_samples.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the sine tone generator testbench: clock, reset, word stimulus with
// bursts and gaps, a stalling receiver and the verdict. Depends on stg_pkg,
// sine_tone_generator_core and sine_tone_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stg_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT_WORD = 150;
  localparam int PHASE_WORDS  = 65;
  localparam int SETTINGS_N   = 6;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [STEP_BITS-1:0] cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;
  logic [1:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;
  logic                 out_tlast;

  int fail_count;
  int pending;
  int words_sent  = 0;
  int burst_left  = 0;
  int cycle_count = 0;

  logic [STEP_BITS-1:0] step_set[SETTINGS_N];
  logic [GAIN_BITS-1:0] gain_set[SETTINGS_N];

  sine_tone_generator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  sine_tone_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: changing stall patterns, and one long hold-off once the run is under way.
  initial begin
    int  cyc;
    int  mode;
    bit  held;
    cyc  = 0;
    mode = 0;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!held && words_sent >= HOLD_AT_WORD) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (cyc % 48 == 0) begin
        mode = $urandom_range(0, 3);
      end
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= (cyc % 5 != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offers one word and waits for it to be taken; gaps fall between bursts.
  task automatic send_word(input stg_op_t op, input logic [23:0] dur);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= dur;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  // Waits until every sample has arrived and any control word has settled.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Writes both registers; the gain write carries junk in its unused upper bits.
  task automatic apply_setting(input logic [STEP_BITS-1:0] step,
                               input logic [GAIN_BITS-1:0] gain);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PHASE_STEP;
    cfg_wdata <= step;
    @(negedge clk);
    cfg_index <= REG_GAIN;
    cfg_wdata <= {15'($urandom), gain};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly whole tones (play then ticks), with stray control words mixed in.
  task automatic run_random(input int count);
    int          first;
    int          ticks;
    logic [23:0] dur;
    first = words_sent;
    while (words_sent - first < count) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0:       dur = 24'd0;
          1:       dur = 24'($urandom_range(13, 60));
          2:       dur = 24'($urandom);
          default: dur = 24'($urandom_range(1, 12));
        endcase
        send_word(OP_PLAY, dur);
        ticks = (dur > 24'd60) ? $urandom_range(1, 10)
                               : ((dur == 24'd0) ? 1 : int'(dur)) + $urandom_range(0, 2);
        for (int i = 0; i < ticks; i++) begin
          case ($urandom_range(0, 39))
            0:       send_word(OP_STOP, 24'($urandom));
            1:       send_word(OP_START, 24'($urandom));
            default: send_word(OP_TICK, 24'($urandom));
          endcase
        end
        if (dur > 24'd60) begin
          send_word(OP_STOP, 24'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(stg_op_t'($urandom_range(0, 3)), 24'($urandom));
        end
      end
    end
  endtask

  // Main sequence: reset, directed words, then random phases under several settings.
  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_PHASE_STEP;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_TICK;

    step_set[0] = 31'h7FFF_FFFF;  gain_set[0] = 16'd32768;
    step_set[1] = 31'd0;          gain_set[1] = 16'hFFFF;
    step_set[2] = 31'h4000_0000;  gain_set[2] = 16'd0;
    step_set[3] = 31'h0040_0000;  gain_set[3] = 16'd32768;
    step_set[4] = 31'($urandom);  gain_set[4] = 16'($urandom);
    step_set[5] = 31'($urandom);  gain_set[5] = 16'($urandom_range(0, 32768));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the reset settings.
    send_word(OP_TICK, 24'hFF_FFFF);   // silent before anything runs
    send_word(OP_START, 24'd0);
    send_word(OP_TICK, 24'd0);         // running but no frames loaded
    send_word(OP_PLAY, 24'd0);         // zero length plays one frame
    send_word(OP_TICK, 24'd0);
    send_word(OP_TICK, 24'd0);
    send_word(OP_PLAY, 24'd3);
    repeat (4) send_word(OP_TICK, 24'h00_0F0F);
    send_word(OP_PLAY, 24'hFF_FFFF);
    send_word(OP_TICK, 24'hAA_AAAA);
    send_word(OP_TICK, 24'h55_5555);
    send_word(OP_STOP, 24'hFF_FFFF);
    send_word(OP_TICK, 24'd0);         // stopped mid-tone
    send_word(OP_START, 24'hFF_FFFF);
    send_word(OP_TICK, 24'd0);
    send_word(OP_PLAY, 24'd5);
    send_word(OP_PLAY, 24'd1);         // a new play overrides the count
    send_word(OP_TICK, 24'd0);
    send_word(OP_TICK, 24'hFF_FFFF);
    wait_quiet();

    for (int s = 0; s < SETTINGS_N; s++) begin
      apply_setting(step_set[s], gain_set[s]);
      run_random(PHASE_WORDS);
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/stg_pkg.sv
design/sine_tone_generator_core.sv
tb/sine_tone_checker.sv
tb/tb.sv
